// File: rtl/trs_pkg.sv
// Shared types and constants for the three-wire serial responder.
// Holds the input word, result word and configuration layouts and the command codes.
// No dependencies.
package trs_pkg;

	localparam int unsigned STORE_DEPTH_DEF = 256;
	localparam int unsigned CFG_W           = 16;
	localparam int unsigned CNT_W           = 17;

	localparam logic [7:0] CODE_RECEIVE = 8'h01;
	localparam logic [7:0] CODE_SEND    = 8'h02;

	localparam logic [CFG_W-1:0] CLOCK_HALF_RST = 16'd10;
	localparam logic [CFG_W-1:0] BYTE_GAP_RST   = 16'd50;
	localparam logic [CFG_W-1:0] SETUP_WAIT_RST = 16'd1000;

	typedef enum logic [1:0] {
		CFG_CLOCK_HALF = 2'd0,
		CFG_BYTE_GAP   = 2'd1,
		CFG_SETUP_WAIT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] clock_half;
		logic [CFG_W-1:0] byte_gap;
		logic [CFG_W-1:0] setup_wait;
	} cfg_t;

	typedef struct packed {
		logic       func;
		logic       select_level;
		logic       line_level;
		logic [7:0] store_index;
		logic [7:0] store_data;
	} item_t;

	typedef struct packed {
		logic        clock_level;
		logic        drive_enable;
		logic        drive_level;
		logic        rx_valid;
		logic [7:0]  rx_byte;
		logic [15:0] byte_position;
		logic        cmd_valid;
		logic [7:0]  cmd_code;
		logic [15:0] cmd_length;
		logic        transfer_done;
		logic        overrun;
	} result_t;

endpackage

// File: rtl/trs_store.sv
// Transmit store: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
module trs_store #(
	parameter int unsigned STORE_DEPTH = 256,
	parameter int unsigned AW          = 8
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [STORE_DEPTH];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// File: rtl/trs_seq.sv
// Line sequencer: phase, counters, shift register and held header.
// Computes one result word per input word; uses trs_pkg and the trs_store read data.
module trs_seq #(
	parameter int unsigned STORE_DEPTH = trs_pkg::STORE_DEPTH_DEF,
	parameter int unsigned AW          = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  trs_pkg::cfg_t    cfg,
	input  trs_pkg::item_t   item,
	input  logic             advance,
	input  logic [7:0]       rd_data,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output logic [7:0]       wr_data,
	output logic             rd_en,
	output logic [AW-1:0]    rd_addr,
	output trs_pkg::result_t res
);
	import trs_pkg::*;

	typedef enum logic [3:0] {
		P_IDLE  = 4'd0,
		P_HLOW  = 4'd1,
		P_HHIGH = 4'd2,
		P_HGAP  = 4'd3,
		P_SETUP = 4'd4,
		P_RLOW  = 4'd5,
		P_RHIGH = 4'd6,
		P_RGAP  = 4'd7,
		P_TPRE  = 4'd8,
		P_TLOW  = 4'd9,
		P_THIGH = 4'd10,
		P_TGAP  = 4'd11,
		P_DESEL = 4'd12,
		P_FINAL = 4'd13
	} phase_t;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);

	phase_t            phase_q, phase_n;
	logic [15:0]       wait_q, wait_n;
	logic [2:0]        bit_q, bit_n;
	logic [CNT_W-1:0]  byte_q, byte_n;
	logic [7:0]        shift_q, shift_n;
	logic              src_mem_q, src_mem_n;
	logic [7:0]        code_q, code_n;
	logic [15:0]       len_q, len_n;

	logic [15:0]       half;
	logic [15:0]       wait_inc;
	logic              hit_half;
	logic [7:0]        shift_eff;
	logic              want_hnext, want_setup, want_data, want_tx, want_rxnext, want_txnext;
	logic [CNT_W-1:0]  store_idx_ext;

	assign half          = (cfg.clock_half == '0) ? 16'd1 : cfg.clock_half;
	assign wait_inc      = wait_q + 16'd1;
	assign hit_half      = wait_inc >= half;
	assign shift_eff     = src_mem_q ? rd_data : shift_q;
	assign store_idx_ext = CNT_W'(item.store_index);

	assign wr_en   = advance && item.func && (store_idx_ext < DEPTH_C);
	assign wr_addr = store_idx_ext[AW-1:0];
	assign wr_data = item.store_data;
	assign rd_addr = byte_n[AW-1:0];

	always_comb begin
		phase_n     = phase_q;
		wait_n      = wait_q;
		bit_n       = bit_q;
		byte_n      = byte_q;
		shift_n     = shift_q;
		src_mem_n   = src_mem_q;
		code_n      = code_q;
		len_n       = len_q;
		rd_en       = 1'b0;
		want_hnext  = 1'b0;
		want_setup  = 1'b0;
		want_data   = 1'b0;
		want_tx     = 1'b0;
		want_rxnext = 1'b0;
		want_txnext = 1'b0;
		res         = '0;

		res.clock_level = (phase_q == P_HHIGH) || (phase_q == P_RHIGH) ||
			(phase_q == P_THIGH) || (phase_q == P_FINAL);
		if ((phase_q == P_TLOW) || (phase_q == P_THIGH) || (phase_q == P_TGAP)) begin
			res.drive_enable  = 1'b1;
			res.drive_level   = (phase_q == P_TGAP) ? shift_eff[0] : shift_eff[3'd7 - bit_q];
			res.byte_position = byte_q[15:0];
			res.overrun       = byte_q >= DEPTH_C;
		end

		if (!item.func) begin
			unique case (phase_q)
				P_IDLE: begin
					if (!item.select_level) begin
						byte_n    = '0;
						bit_n     = '0;
						shift_n   = '0;
						src_mem_n = 1'b0;
						phase_n   = P_HLOW;
						wait_n    = '0;
					end
				end
				P_HLOW, P_RLOW, P_TLOW: begin
					wait_n = wait_inc;
					if (hit_half) begin
						wait_n = '0;
						unique case (phase_q)
							P_HLOW:  phase_n = P_HHIGH;
							P_RLOW:  phase_n = P_RHIGH;
							default: phase_n = P_THIGH;
						endcase
					end
				end
				P_HHIGH, P_RHIGH: begin
					if (wait_q == '0) begin
						shift_n   = {shift_eff[6:0], item.line_level};
						src_mem_n = 1'b0;
					end
					wait_n = wait_inc;
					if (hit_half) begin
						wait_n = '0;
						if (bit_q < 3'd7) begin
							bit_n   = bit_q + 3'd1;
							phase_n = (phase_q == P_HHIGH) ? P_HLOW : P_RLOW;
						end else begin
							bit_n = '0;
							if (phase_q == P_HHIGH) begin
								if (byte_q == CNT_W'(0)) begin
									code_n = shift_n;
								end else if (byte_q == CNT_W'(1)) begin
									len_n = {shift_n, 8'h00};
								end else begin
									len_n          = {len_q[15:8], shift_n};
									res.cmd_valid  = 1'b1;
									res.cmd_code   = code_q;
									res.cmd_length = len_n;
								end
								byte_n = byte_q + CNT_W'(1);
								if (cfg.byte_gap == '0) begin
									want_hnext = 1'b1;
								end else begin
									phase_n = P_HGAP;
								end
							end else begin
								res.rx_valid      = 1'b1;
								res.rx_byte       = shift_n;
								res.byte_position = byte_q[15:0];
								byte_n            = byte_q + CNT_W'(1);
								if (cfg.byte_gap == '0) begin
									want_rxnext = 1'b1;
								end else begin
									phase_n = P_RGAP;
								end
							end
						end
					end
				end
				P_THIGH: begin
					wait_n = wait_inc;
					if (hit_half) begin
						wait_n = '0;
						if (bit_q < 3'd7) begin
							bit_n   = bit_q + 3'd1;
							phase_n = P_TLOW;
						end else begin
							bit_n = '0;
							if (cfg.byte_gap == '0) begin
								want_txnext = 1'b1;
							end else begin
								phase_n = P_TGAP;
							end
						end
					end
				end
				P_HGAP, P_RGAP, P_TGAP, P_TPRE: begin
					wait_n = wait_inc;
					if (wait_inc >= cfg.byte_gap) begin
						unique case (phase_q)
							P_HGAP:  want_hnext  = 1'b1;
							P_RGAP:  want_rxnext = 1'b1;
							P_TGAP:  want_txnext = 1'b1;
							default: want_tx     = 1'b1;
						endcase
					end
				end
				P_SETUP: begin
					wait_n = wait_inc;
					if (wait_inc >= cfg.setup_wait) begin
						want_data = 1'b1;
					end
				end
				P_DESEL: begin
					if (item.select_level) begin
						phase_n = P_FINAL;
						wait_n  = '0;
					end
				end
				P_FINAL: begin
					wait_n = wait_inc;
					if (hit_half) begin
						res.transfer_done = 1'b1;
						phase_n           = P_IDLE;
						wait_n            = '0;
					end
				end
				default: begin
					phase_n = P_IDLE;
					wait_n  = '0;
				end
			endcase

			if (want_hnext) begin
				if (byte_n < CNT_W'(3)) begin
					phase_n = P_HLOW;
					wait_n  = '0;
				end else begin
					want_setup = 1'b1;
				end
			end
			if (want_setup) begin
				if (cfg.setup_wait == '0) begin
					want_data = 1'b1;
				end else begin
					phase_n = P_SETUP;
					wait_n  = '0;
				end
			end
			if (want_data) begin
				byte_n = '0;
				bit_n  = '0;
				wait_n = '0;
				if (code_n == CODE_RECEIVE) begin
					phase_n = (len_n == '0) ? P_DESEL : P_RLOW;
				end else if (code_n == CODE_SEND) begin
					if (cfg.byte_gap == '0) begin
						want_tx = 1'b1;
					end else begin
						phase_n = P_TPRE;
					end
				end else begin
					phase_n = P_DESEL;
				end
			end
			if (want_rxnext) begin
				phase_n = (byte_n >= CNT_W'(len_n)) ? P_DESEL : P_RLOW;
				wait_n  = '0;
			end
			if (want_txnext) begin
				byte_n = {1'b0, byte_q[15:0] + 16'd1};
				if (byte_n == '0) begin
					phase_n = P_DESEL;
					wait_n  = '0;
				end else begin
					want_tx = 1'b1;
				end
			end
			if (want_tx) begin
				wait_n = '0;
				if (byte_n >= CNT_W'(len_n)) begin
					phase_n = P_DESEL;
				end else begin
					bit_n   = '0;
					phase_n = P_TLOW;
					if (byte_n < DEPTH_C) begin
						rd_en     = advance;
						src_mem_n = 1'b1;
					end else begin
						shift_n   = '0;
						src_mem_n = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= P_IDLE;
			wait_q    <= '0;
			bit_q     <= '0;
			byte_q    <= '0;
			shift_q   <= '0;
			src_mem_q <= 1'b0;
			code_q    <= '0;
			len_q     <= '0;
		end else if (advance) begin
			phase_q   <= phase_n;
			wait_q    <= wait_n;
			bit_q     <= bit_n;
			byte_q    <= byte_n;
			shift_q   <= shift_n;
			src_mem_q <= src_mem_n;
			code_q    <= code_n;
			len_q     <= len_n;
		end
	end

endmodule

// File: rtl/three_wire_serial_responder.sv
// Top level of the three-wire serial responder: handshakes, configuration registers,
// input and result registers. Instantiates trs_seq and trs_store; uses trs_pkg.
//
// Usage: each input word is either one timing tick (func 0) carrying the sampled
// select and data lines, or a transmit store write (func 1). Every input word yields
// exactly one result word with the clock and data line levels for that tick and the
// header, receive and completion flags.
// Channels: input and result use valid/ready; configuration is a plain write port
// (cfg_we, cfg_index, cfg_data) taken at any edge with cfg_we high; the user must
// write it only while idle; the block does not enforce it. Path: a word is held in
// the input register, processed combinationally and shown from the result register.
// Throughput: one word per cycle while out_ready stays high; the sequencer state
// and the store read register update only as a word moves into the result register.
// Reset: the sequencer returns to waiting for select low and the configuration
// registers take 10, 50 and 1000 ticks; store contents stay unknown until written.
// Stall: while out_ready is low the result word holds; the input register still
// takes one more word if it is empty, then in_ready drops until the result is taken.
module three_wire_serial_responder #(
	parameter int unsigned STORE_DEPTH = trs_pkg::STORE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [trs_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       func,
	input  logic                       select_level,
	input  logic                       line_level,
	input  logic [7:0]                 store_index,
	input  logic [7:0]                 store_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       clock_level,
	output logic                       drive_enable,
	output logic                       drive_level,
	output logic                       rx_valid,
	output logic [7:0]                 rx_byte,
	output logic [15:0]                byte_position,
	output logic                       cmd_valid,
	output logic [7:0]                 cmd_code,
	output logic [15:0]                cmd_length,
	output logic                       transfer_done,
	output logic                       overrun
);
	import trs_pkg::*;

	localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1_q;
	result_t res_comb, res_q;
	logic    out_valid_q;
	logic    advance;

	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [7:0]    wr_data, rd_data;

	assign advance  = valid_s1_q && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clock_half <= CLOCK_HALF_RST;
			cfg_q.byte_gap   <= BYTE_GAP_RST;
			cfg_q.setup_wait <= SETUP_WAIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CLOCK_HALF: cfg_q.clock_half <= cfg_data;
				CFG_BYTE_GAP:   cfg_q.byte_gap   <= cfg_data;
				CFG_SETUP_WAIT: cfg_q.setup_wait <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1_q <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{func: func, select_level: select_level, line_level: line_level,
				store_index: store_index, store_data: store_data};
		end
		if (advance) begin
			res_q <= res_comb;
		end
	end

	trs_seq #(
		.STORE_DEPTH (STORE_DEPTH),
		.AW          (AW)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.item    (item_s1),
		.advance (advance),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.res     (res_comb)
	);

	trs_store #(
		.STORE_DEPTH (STORE_DEPTH),
		.AW          (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign out_valid     = out_valid_q;
	assign clock_level   = res_q.clock_level;
	assign drive_enable  = res_q.drive_enable;
	assign drive_level   = res_q.drive_level;
	assign rx_valid      = res_q.rx_valid;
	assign rx_byte       = res_q.rx_byte;
	assign byte_position = res_q.byte_position;
	assign cmd_valid     = res_q.cmd_valid;
	assign cmd_code      = res_q.cmd_code;
	assign cmd_length    = res_q.cmd_length;
	assign transfer_done = res_q.transfer_done;
	assign overrun       = res_q.overrun;

endmodule
